// File: design/slmf_pkg.sv
// shared constants and controller/datapath interface types for the sensor line mode filter
`default_nettype none

package slmf_pkg;

    // batch size and derived widths
    localparam int NUM_SAMPLES = 10;
    localparam int IDX_W       = $clog2(NUM_SAMPLES);
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;

    // ascii codes the parser reacts to
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // commands from controller to datapath
    typedef struct packed {
        logic byte_take;    // input transfer this cycle
        logic search_start; // clear best count, point i at entry 0
        logic sel_j;        // read address from j instead of i
        logic lat_i;        // capture entry i, set up inner scan
        logic cmp;          // compare entry j, advance j
        logic upd;          // fold count of entry i into best, advance i
        logic out_load;     // move best into output register
    } slmf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic batch_full;   // current byte completes a batch
        logic i_last;       // i points at the last entry
        logic j_last;       // j points at the last entry
    } slmf_stat_t;

endpackage

`default_nettype wire

// File: design/slmf_ctrl.sv
// controller state machine: byte intake, mode search sequencing, output handoff
`default_nettype none

module slmf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire slmf_pkg::slmf_stat_t stat,
    output slmf_pkg::slmf_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_I,
        S_LAT_I,
        S_RD_J,
        S_CMP,
        S_UPD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   take;
    logic   load;

    // intake only in the idle state, not during the search or the output handoff
    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready;
    assign load     = (state_reg == S_OUT) && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;

    // command decode
    always_comb
    begin
        cmd              = '0;
        cmd.byte_take    = take;
        cmd.search_start = take && stat.batch_full;
        cmd.sel_j        = (state_reg == S_RD_J);
        cmd.lat_i        = (state_reg == S_LAT_I);
        cmd.cmp          = (state_reg == S_CMP);
        cmd.upd          = (state_reg == S_UPD);
        cmd.out_load     = load;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && stat.batch_full)
                begin
                    state_next = S_RD_I;
                end
            end
            S_RD_I:  state_next = S_LAT_I;
            S_LAT_I: state_next = stat.i_last ? S_UPD : S_RD_J;
            S_RD_J:  state_next = S_CMP;
            S_CMP:   state_next = stat.j_last ? S_UPD : S_RD_J;
            S_UPD:   state_next = stat.i_last ? S_OUT : S_RD_I;
            S_OUT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output valid: a new load wins over a completed transfer
    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/slmf_dp.sv
// datapath: line parser, sample memory, mode search registers, output register
`default_nettype none

module slmf_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [slmf_pkg::BYTE_W-1:0]          rx_byte,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_data,
    input  wire slmf_pkg::slmf_cmd_t                  cmd,
    output slmf_pkg::slmf_stat_t                      stat,
    output logic signed [slmf_pkg::SAMPLE_W-1:0]      mode_value
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    localparam logic [slmf_pkg::IDX_W-1:0] LAST_IDX =
        slmf_pkg::IDX_W'(slmf_pkg::NUM_SAMPLES - 1);

    // configuration and parser state
    logic                            fmt_reg;
    phase_t                          phase_reg, phase_next;
    logic [slmf_pkg::SAMPLE_W-1:0]   acc_reg, acc_next;
    logic                            neg_reg, neg_next;
    logic                            disc_reg, disc_next;
    logic [slmf_pkg::IDX_W-1:0]      count_reg, count_next;

    // sample memory
    logic [slmf_pkg::SAMPLE_W-1:0]   mem [slmf_pkg::NUM_SAMPLES];
    logic [slmf_pkg::IDX_W-1:0]      rd_addr;
    logic [slmf_pkg::SAMPLE_W-1:0]   rd_data_reg;
    logic                            wr_en;
    logic [slmf_pkg::SAMPLE_W-1:0]   wr_value;

    // search state
    logic [slmf_pkg::IDX_W-1:0]      i_reg;
    logic [slmf_pkg::IDX_W-1:0]      j_reg;
    logic [slmf_pkg::SAMPLE_W-1:0]   cur_reg;
    logic [slmf_pkg::IDX_W-1:0]      n_reg;
    logic [slmf_pkg::IDX_W-1:0]      best_n_reg;
    logic [slmf_pkg::SAMPLE_W-1:0]   best_reg;
    logic [slmf_pkg::SAMPLE_W-1:0]   mode_reg;

    // byte classes
    logic                            is_cr;
    logic                            is_digit;
    logic                            is_blank;
    logic [3:0]                      digit;
    logic [slmf_pkg::SAMPLE_W-1:0]   acc_x10;
    logic [slmf_pkg::SAMPLE_W-1:0]   signed_val;

    assign is_cr    = (rx_byte == slmf_pkg::CHAR_CR);
    assign is_digit = (rx_byte >= slmf_pkg::CHAR_ZERO) && (rx_byte <= slmf_pkg::CHAR_NINE);
    assign is_blank = (rx_byte == slmf_pkg::CHAR_SPACE) ||
                      ((rx_byte >= slmf_pkg::CHAR_TAB) && (rx_byte <= slmf_pkg::CHAR_FF));
    assign digit    = rx_byte[3:0];
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1);

    // reading at line end: sign, then format cut
    assign signed_val = neg_reg ? (slmf_pkg::SAMPLE_W'(0) - acc_reg) : acc_reg;
    assign wr_value   = fmt_reg ? {8'h00, signed_val[7:0]} : signed_val;
    assign wr_en      = cmd.byte_take && is_cr && !disc_reg;

    assign stat.batch_full = is_cr && !disc_reg && (count_reg == LAST_IDX);
    assign stat.i_last     = (i_reg == LAST_IDX);
    assign stat.j_last     = (j_reg == LAST_IDX);

    // parser next state
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        disc_next  = disc_reg;
        count_next = count_reg;
        if (cmd.byte_take)
        begin
            if (is_cr)
            begin
                phase_next = PH_SPACE;
                acc_next   = '0;
                neg_next   = 1'b0;
                disc_next  = 1'b0;
                if (!disc_reg)
                begin
                    count_next = (count_reg == LAST_IDX) ? '0
                               : slmf_pkg::IDX_W'(count_reg + 1'b1);
                end
            end
            else
            begin
                if (rx_byte == slmf_pkg::CHAR_STAR)
                begin
                    disc_next = 1'b1;
                end
                unique case (phase_reg)
                    PH_SPACE:
                    begin
                        priority if (is_blank)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (rx_byte == slmf_pkg::CHAR_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else if (rx_byte == slmf_pkg::CHAR_PLUS)
                        begin
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = slmf_pkg::SAMPLE_W'(digit);
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            acc_next = acc_x10 + slmf_pkg::SAMPLE_W'(digit);
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= 1'b0;
            phase_reg <= PH_SPACE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            disc_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            disc_reg  <= disc_next;
            count_reg <= count_next;
        end
    end

    // sample memory, one write and one registered read
    assign rd_addr = cmd.sel_j ? j_reg : i_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg] <= wr_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // mode search: count later matches of each entry, keep last best
    always_ff @(posedge clk)
    begin
        if (cmd.search_start)
        begin
            i_reg      <= '0;
            best_n_reg <= '0;
        end
        if (cmd.lat_i)
        begin
            cur_reg <= rd_data_reg;
            n_reg   <= '0;
            j_reg   <= slmf_pkg::IDX_W'(i_reg + 1'b1);
        end
        if (cmd.cmp)
        begin
            if (rd_data_reg == cur_reg)
            begin
                n_reg <= slmf_pkg::IDX_W'(n_reg + 1'b1);
            end
            j_reg <= slmf_pkg::IDX_W'(j_reg + 1'b1);
        end
        if (cmd.upd)
        begin
            if (n_reg >= best_n_reg)
            begin
                best_n_reg <= n_reg;
                best_reg   <= cur_reg;
            end
            i_reg <= slmf_pkg::IDX_W'(i_reg + 1'b1);
        end
        if (cmd.out_load)
        begin
            mode_reg <= best_reg;
        end
    end

    assign mode_value = mode_reg;

endmodule

`default_nettype wire

// File: design/sensor_line_mode_filter.sv
// top level of the sensor line mode filter: controller plus datapath
`default_nettype none

// Takes sensor reply text one byte per transfer and parses each CR-terminated
// line into a reading (lines holding '*' are dropped); after NUM_SAMPLES
// readings it emits their mode on the master side. A byte that does not
// complete a batch leaves the slave side ready, so the next byte can follow at
// once. The CR that completes a batch starts the mode search, which scans the
// sample memory through its single read port and then loads the output
// register; until that load the slave side is not ready. The result waits
// in that register, so new bytes are taken while it is pending; a second
// result waits for it to leave.
module sensor_line_mode_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // slave side, tdata: [7:0] rx_byte
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [slmf_pkg::BYTE_W-1:0]          s_tdata,
    // master side, tdata: [15:0] mode_value
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic signed [slmf_pkg::SAMPLE_W-1:0]      m_tdata,
    // reading_format register
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_data
);

    slmf_pkg::slmf_cmd_t  cmd;
    slmf_pkg::slmf_stat_t stat;

    // sequencing
    slmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parsing, storage and search
    slmf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .mode_value (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/tb_sensor_line_mode_filter.sv
// self-checking testbench for the sensor line mode filter: byte stream in, batch modes out
`default_nettype none

module tb_sensor_line_mode_filter;

    typedef enum logic [1:0] {SCAN_BLANK, SCAN_DIGITS, SCAN_DONE} scan_phase_t;

    localparam int SEARCH_CYCLES = 130;
    localparam int RANDOM_BYTES  = 610;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [slmf_pkg::BYTE_W-1:0]          s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic signed [slmf_pkg::SAMPLE_W-1:0] m_tdata;
    logic                                 cfg_we;
    logic                                 cfg_data;

    sensor_line_mode_filter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] mode_value
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // bytes waiting to be sent and modes waiting to be seen
    logic [slmf_pkg::BYTE_W-1:0]          rx_feed_q[$];
    logic signed [slmf_pkg::SAMPLE_W-1:0] mode_expect_q[$];
    bit                                   byte_held;
    int                                   send_idle_pct;
    int                                   recv_idle_pct;
    int                                   err_count;

    // shadow of the parser and batch store
    bit                                   fmt_byte;
    logic [slmf_pkg::SAMPLE_W-1:0]        batch_store[slmf_pkg::NUM_SAMPLES];
    int                                   batch_fill;
    logic [slmf_pkg::SAMPLE_W-1:0]        line_acc;
    bit                                   line_neg;
    bit                                   line_drop;
    scan_phase_t                          scan_state;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // most frequent stored reading, later index wins a tie
    function automatic logic [slmf_pkg::SAMPLE_W-1:0] batch_mode();
        logic [slmf_pkg::SAMPLE_W-1:0] best;
        int                            best_n;
        int                            n;
        best   = batch_store[0];
        best_n = 0;
        for (int i = 0; i < slmf_pkg::NUM_SAMPLES; i++)
        begin
            n = 0;
            for (int j = i + 1; j < slmf_pkg::NUM_SAMPLES; j++)
                if (batch_store[i] == batch_store[j])
                    n++;
            if (n >= best_n)
            begin
                best_n = n;
                best   = batch_store[i];
            end
        end
        return best;
    endfunction

    // advance the line parser by one byte, returns 1 when a batch completes
    function automatic bit parse_rx_byte(input logic [slmf_pkg::BYTE_W-1:0] c,
                                         output logic signed [slmf_pkg::SAMPLE_W-1:0] mode);
        logic [slmf_pkg::SAMPLE_W-1:0] v;
        bit                            done;
        done = 1'b0;
        mode = '0;
        if (c == slmf_pkg::CHAR_CR)
        begin
            if (!line_drop)
            begin
                v = line_acc;
                if (line_neg)
                    v = -v;
                if (fmt_byte)
                    v = {8'h00, v[7:0]};
                batch_store[batch_fill] = v;
                batch_fill++;
                if (batch_fill >= slmf_pkg::NUM_SAMPLES)
                begin
                    mode       = batch_mode();
                    batch_fill = 0;
                    done       = 1'b1;
                end
            end
            line_acc   = '0;
            line_neg   = 1'b0;
            line_drop  = 1'b0;
            scan_state = SCAN_BLANK;
            return done;
        end
        if (c == slmf_pkg::CHAR_STAR)
            line_drop = 1'b1;
        case (scan_state)
            SCAN_BLANK:
            begin
                if (c == slmf_pkg::CHAR_SPACE ||
                    (c >= slmf_pkg::CHAR_TAB && c <= slmf_pkg::CHAR_FF))
                    scan_state = SCAN_BLANK;
                else if (c == slmf_pkg::CHAR_MINUS)
                begin
                    line_neg   = 1'b1;
                    scan_state = SCAN_DIGITS;
                end
                else if (c == slmf_pkg::CHAR_PLUS)
                    scan_state = SCAN_DIGITS;
                else if (c >= slmf_pkg::CHAR_ZERO && c <= slmf_pkg::CHAR_NINE)
                begin
                    line_acc   = slmf_pkg::SAMPLE_W'(c - slmf_pkg::CHAR_ZERO);
                    scan_state = SCAN_DIGITS;
                end
                else
                    scan_state = SCAN_DONE;
            end
            SCAN_DIGITS:
            begin
                if (c >= slmf_pkg::CHAR_ZERO && c <= slmf_pkg::CHAR_NINE)
                    line_acc = line_acc * 16'd10
                             + slmf_pkg::SAMPLE_W'(c - slmf_pkg::CHAR_ZERO);
                else
                    scan_state = SCAN_DONE;
            end
            default: ;
        endcase
        return done;
    endfunction

    // sender: offer the next byte, hold it until the transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!byte_held)
            begin
                if (rx_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tdata   <= rx_feed_q.pop_front();
                    s_tvalid  <= 1'b1;
                    byte_held = 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // input transfers feed the shadow parser, output transfers are checked
    always @(posedge clk)
    begin
        logic signed [slmf_pkg::SAMPLE_W-1:0] mode;
        logic signed [slmf_pkg::SAMPLE_W-1:0] want;
        if (s_tvalid && s_tready)
        begin
            byte_held = 1'b0;
            if (parse_rx_byte(s_tdata, mode))
                mode_expect_q.push_back(mode);
        end
        if (m_tvalid && m_tready)
        begin
            if (mode_expect_q.size() == 0)
            begin
                $display("%0t unexpected mode_value: expected none actual %0d",
                         $time, m_tdata);
                err_count++;
            end
            else
            begin
                want = mode_expect_q.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t mode_value mismatch: expected %0d actual %0d",
                             $time, want, m_tdata);
                    err_count++;
                end
            end
        end
    end

    task automatic write_format(input bit v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        fmt_byte = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued byte is sent, every pending mode has arrived and the search is over
    task automatic wait_drained();
        while (rx_feed_q.size() != 0 || byte_held || mode_expect_q.size() != 0)
            @(negedge clk);
        repeat (SEARCH_CYCLES) @(posedge clk);
    endtask

    task automatic queue_line(input string body);
        for (int i = 0; i < body.len(); i++)
            rx_feed_q.push_back(body[i]);
        rx_feed_q.push_back(slmf_pkg::CHAR_CR);
    endtask

    // one random line: mostly a well-formed number, sometimes noise or a broken prefix
    task automatic queue_random_line(output int n_bytes);
        logic [slmf_pkg::BYTE_W-1:0] line_q[$];
        int                          kind;
        int                          len;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // raw noise, may or may not hold a CR
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                line_q.push_back(slmf_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < len; i++)
                line_q.push_back($urandom_range(0, 1) ? slmf_pkg::CHAR_SPACE
                                 : slmf_pkg::BYTE_W'(slmf_pkg::CHAR_TAB
                                                     + $urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: line_q.push_back(slmf_pkg::CHAR_MINUS);
                1: line_q.push_back(slmf_pkg::CHAR_PLUS);
                default: ;
            endcase
            if (kind == 1)
            begin
                // possibly broken prefix: a second sign, or a blank when a sign came first
                line_q.push_back($urandom_range(0, 1) ? slmf_pkg::CHAR_MINUS
                                                      : slmf_pkg::CHAR_SPACE);
                line_q.push_back(slmf_pkg::BYTE_W'(slmf_pkg::CHAR_ZERO
                                                   + $urandom_range(0, 9)));
            end
            else if ($urandom_range(0, 1))
                line_q.push_back(slmf_pkg::BYTE_W'(slmf_pkg::CHAR_ZERO
                                                   + $urandom_range(0, 3)));
            else
            begin
                len = $urandom_range(0, 5) == 0 ? $urandom_range(4, 7)
                                                : $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    line_q.push_back(slmf_pkg::BYTE_W'(slmf_pkg::CHAR_ZERO
                                                       + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0)
                line_q.push_back(slmf_pkg::BYTE_W'($urandom_range(32, 126)));
            if ($urandom_range(0, 9) == 0)
                line_q.insert($urandom_range(0, line_q.size()), slmf_pkg::CHAR_STAR);
            line_q.push_back(slmf_pkg::CHAR_CR);
        end
        n_bytes = line_q.size();
        foreach (line_q[i])
            rx_feed_q.push_back(line_q[i]);
    endtask

    task automatic queue_random_bytes(input int target);
        int total;
        int n;
        total = 0;
        while (total < target)
        begin
            queue_random_line(n);
            total += n;
        end
    endtask

    // run limit
    initial
    begin
        #2000000;
        $display("sensor_line_mode_filter verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = 1'b0;
        byte_held     = 1'b0;
        err_count     = 0;
        fmt_byte      = 1'b0;
        batch_fill    = 0;
        line_acc      = '0;
        line_neg      = 1'b0;
        line_drop     = 1'b0;
        scan_state    = SCAN_BLANK;
        send_idle_pct = 31;
        recv_idle_pct = 45;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: blanks and sign, lone sign, empty line, overflow, star drop,
        // blank after sign
        write_format(1'b0);
        queue_line(" \t-7x");
        queue_line("+");
        queue_line("");
        queue_line("99999");
        queue_line("4*2");
        queue_line("- 3");
        wait_drained();

        // random, 8-bit readings, both sides idle
        write_format(1'b1);
        queue_random_bytes(RANDOM_BYTES);
        wait_drained();

        // random, 16-bit readings, idle rates swapped
        send_idle_pct = 45;
        recv_idle_pct = 31;
        write_format(1'b0);
        queue_random_bytes(RANDOM_BYTES);
        wait_drained();

        // random, 8-bit readings, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_format(1'b1);
        queue_random_bytes(RANDOM_BYTES);
        wait_drained();

        if (err_count == 0)
            $display("sensor_line_mode_filter verification clean");
        else
            $display("sensor_line_mode_filter verification failed");
        $finish;
    end

endmodule

`default_nettype wire
